@@ rtl/x86enc_pkg.sv @@
// ----------------------------------------------------------------------------
// x86enc_pkg
// Shared types and codes for the x86-64 instruction encoder.
// ----------------------------------------------------------------------------
`default_nettype none
package x86enc_pkg;

    localparam int MaxAlign   = 64;
    localparam int EncBytes   = 10;   // longest non-align encoding (movabs)
    localparam int LenW       = 7;    // up to MaxAlign-1 pad bytes
    localparam int IdxW       = 4;

    localparam logic [4:0] F_MOVRR = 5'd0,  F_MOVRI = 5'd1,  F_LOAD  = 5'd2,
                           F_STORE = 5'd3,  F_ADD   = 5'd4,  F_SUB   = 5'd5,
                           F_AND   = 5'd6,  F_OR    = 5'd7,  F_XOR   = 5'd8,
                           F_CMP   = 5'd9,  F_TEST  = 5'd10, F_IMUL  = 5'd11,
                           F_SHL   = 5'd12, F_SAR   = 5'd13, F_JMP   = 5'd14,
                           F_JMPS  = 5'd15, F_JCC   = 5'd16, F_JCCS  = 5'd17,
                           F_CALL  = 5'd18, F_RET   = 5'd19, F_PUSH  = 5'd20,
                           F_POP   = 5'd21, F_SETCC = 5'd22, F_MOVZX = 5'd23,
                           F_ALIGN = 5'd24;

    localparam logic [7:0] OP_NOP = 8'h90;

    localparam logic REG_CAP = 1'b0;

    typedef struct packed {
        logic [4:0]         func;
        logic [3:0]         reg_a;
        logic [3:0]         reg_b;
        logic signed [63:0] immediate;
        logic [3:0]         condition;
    } t_in_item;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last_byte;
        logic       overflow;
    } t_out_item;

    typedef struct packed {
        logic [EncBytes-1:0][7:0] bytes;
        logic [LenW-1:0]          len;
        logic                     is_align;
        logic                     bad;
    } t_enc;

endpackage
`default_nettype wire

@@ rtl/x86enc_encode.sv @@
// ----------------------------------------------------------------------------
// x86enc_encode
// Combinational encoding of one instruction into bytes and a length.
// ----------------------------------------------------------------------------
`default_nettype none
module x86enc_encode import x86enc_pkg::*; (
    input  wire t_in_item    i_item,
    input  wire logic [31:0] i_offset,
    output t_enc             o_enc
);

    always_comb begin
        logic [EncBytes-1:0][7:0] b;
        logic [IdxW-1:0] k;
        logic [3:0]  ra, rb;
        logic [63:0] imm;
        logic [31:0] lo;
        logic [1:0]  md;
        logic [7:0]  rex_ab, rex_ba, rex_0a, aop;
        logic [6:0]  am1;
        b      = '0;
        k      = '0;
        ra     = i_item.reg_a;
        rb     = i_item.reg_b;
        imm    = i_item.immediate;
        lo     = imm[31:0];
        rex_ab = 8'h48 | {5'd0, ra[3], 1'b0, rb[3]};
        rex_ba = 8'h48 | {5'd0, rb[3], 1'b0, ra[3]};
        rex_0a = 8'h48 | {7'd0, ra[3]};
        am1    = imm[6:0] - 7'd1;
        md     = 2'd2;
        aop    = 8'h01;
        o_enc.is_align = 1'b0;
        o_enc.bad      = 1'b0;
        o_enc.len      = '0;
        case (i_item.func)
            F_MOVRR: begin
                if (ra != rb) begin
                    b[0] = rex_ab; b[1] = 8'h8B; b[2] = {2'b11, ra[2:0], rb[2:0]};
                    k = 4'd3;
                end
            end
            F_MOVRI: begin
                if (imm[63:32] == '0) begin
                    if (ra[3]) begin
                        b[k] = 8'h41; k = k + 4'd1;
                    end
                    b[k] = 8'hB8 | {5'd0, ra[2:0]}; k = k + 4'd1;
                    b[k] = lo[7:0];   k = k + 4'd1;
                    b[k] = lo[15:8];  k = k + 4'd1;
                    b[k] = lo[23:16]; k = k + 4'd1;
                    b[k] = lo[31:24]; k = k + 4'd1;
                end else if (&imm[63:31]) begin
                    b[0] = rex_0a; b[1] = 8'hC7; b[2] = {5'b11000, ra[2:0]};
                    b[3] = lo[7:0]; b[4] = lo[15:8]; b[5] = lo[23:16]; b[6] = lo[31:24];
                    k = 4'd7;
                end else begin
                    b[0] = rex_0a; b[1] = 8'hB8 | {5'd0, ra[2:0]};
                    for (int i = 0; i < 8; i++) b[2+i] = imm[8*i +: 8];
                    k = 4'd10;
                end
            end
            F_LOAD, F_STORE: begin
                if (lo == '0 && rb[2:0] != 3'd5)      md = 2'd0;
                else if (lo[31:7] == '0 || &lo[31:7]) md = 2'd1;
                b[0] = rex_ab;
                b[1] = (i_item.func == F_LOAD) ? 8'h8B : 8'h89;
                b[2] = {md, ra[2:0], rb[2:0]};
                k = 4'd3;
                if (rb[2:0] == 3'd4) begin
                    b[k] = 8'h24; k = k + 4'd1;
                end
                if (md == 2'd1) begin
                    b[k] = lo[7:0]; k = k + 4'd1;
                end else if (md == 2'd2) begin
                    b[k] = lo[7:0];   k = k + 4'd1;
                    b[k] = lo[15:8];  k = k + 4'd1;
                    b[k] = lo[23:16]; k = k + 4'd1;
                    b[k] = lo[31:24]; k = k + 4'd1;
                end
            end
            F_ADD, F_SUB, F_AND, F_OR, F_XOR, F_CMP, F_TEST: begin
                case (i_item.func)
                    F_ADD:   aop = 8'h01;
                    F_SUB:   aop = 8'h29;
                    F_AND:   aop = 8'h21;
                    F_OR:    aop = 8'h09;
                    F_XOR:   aop = 8'h31;
                    F_CMP:   aop = 8'h39;
                    default: aop = 8'h85;
                endcase
                b[0] = rex_ba; b[1] = aop; b[2] = {2'b11, rb[2:0], ra[2:0]};
                k = 4'd3;
            end
            F_IMUL, F_MOVZX: begin
                b[0] = rex_ab; b[1] = 8'h0F;
                b[2] = (i_item.func == F_IMUL) ? 8'hAF : 8'hB6;
                b[3] = {2'b11, ra[2:0], rb[2:0]};
                k = 4'd4;
            end
            F_SHL, F_SAR: begin
                b[0] = rex_0a;
                b[1] = (lo[7:0] == 8'd1) ? 8'hD1 : 8'hC1;
                b[2] = {2'b11, (i_item.func == F_SHL) ? 3'd4 : 3'd7, ra[2:0]};
                b[3] = lo[7:0];
                k = (lo[7:0] == 8'd1) ? 4'd3 : 4'd4;
            end
            F_JMP: begin
                b[0] = 8'hE9; b[1] = lo[7:0]; b[2] = lo[15:8]; b[3] = lo[23:16];
                b[4] = lo[31:24];
                k = 4'd5;
            end
            F_JMPS: begin
                b[0] = 8'hEB; b[1] = lo[7:0]; k = 4'd2;
            end
            F_JCC: begin
                b[0] = 8'h0F; b[1] = {4'h8, i_item.condition};
                b[2] = lo[7:0]; b[3] = lo[15:8]; b[4] = lo[23:16]; b[5] = lo[31:24];
                k = 4'd6;
            end
            F_JCCS: begin
                b[0] = {4'h7, i_item.condition}; b[1] = lo[7:0]; k = 4'd2;
            end
            F_CALL: begin
                if (ra[3]) begin
                    b[k] = 8'h41; k = k + 4'd1;
                end
                b[k] = 8'hFF; k = k + 4'd1;
                b[k] = {5'b11010, ra[2:0]}; k = k + 4'd1;
            end
            F_RET: begin
                b[0] = 8'hC3; k = 4'd1;
            end
            F_PUSH, F_POP: begin
                if (ra[3]) begin
                    b[k] = 8'h41; k = k + 4'd1;
                end
                b[k] = ((i_item.func == F_PUSH) ? 8'h50 : 8'h58) | {5'd0, ra[2:0]};
                k = k + 4'd1;
            end
            F_SETCC: begin
                if (ra >= 4'd4) begin
                    b[k] = ra[3] ? 8'h41 : 8'h40; k = k + 4'd1;
                end
                b[k] = 8'h0F; k = k + 4'd1;
                b[k] = {4'h9, i_item.condition}; k = k + 4'd1;
                b[k] = {5'b11000, ra[2:0]}; k = k + 4'd1;
            end
            F_ALIGN: begin
                o_enc.is_align = 1'b1;
                if (imm[63:7] != '0 || !$onehot(imm[6:0])) begin
                    o_enc.bad = 1'b1;
                end
            end
            default: begin
            end
        endcase
        o_enc.bytes = b;
        if (o_enc.is_align) begin
            o_enc.len = o_enc.bad ? '0
                      : {1'b0, (6'd0 - i_offset[5:0]) & am1[5:0]};
        end else begin
            o_enc.len = {3'd0, k};
        end
    end

endmodule
`default_nettype wire

@@ rtl/x86_64_instruction_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// x86_64_instruction_encoder_unit
// Encodes instruction requests into x86-64 machine-code bytes, one per word.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+------------------------------
//  in       | in        | i_valid / o_ready   | i_in  (t_in_item)
//  out      | out       | o_valid / i_ready   | o_out (t_out_item), one byte
//  cfg      | in        | APB psel/penable    | buffer_capacity at address 0
//
//  An instruction of N bytes leaves as N output words (one for overflow); the
//  byte serializer in the result register sends them. Items that emit nothing
//  pass only through the input register. The next item is encoded while the
//  current one's last byte leaves, so a waiting nonempty item adds no gap.
//  Synchronous active-low reset: capacity 4096, offset 0, both stages empty.
//  A stalled output holds its word; the input register then holds too.
// ----------------------------------------------------------------------------
`default_nettype none
module x86_64_instruction_encoder_unit import x86enc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_in_item    i_in,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_out_item        o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // configuration
    logic [31:0] r_cap;
    logic [31:0] r_offset;

    // input register
    logic     r_in_vld;
    t_in_item r_in;

    // result register / byte serializer
    logic                     r_busy;
    logic                     r_ovf;
    logic                     r_align;
    logic [EncBytes-1:0][7:0] r_bytes;
    logic [LenW-1:0]          r_len;
    logic [LenW-1:0]          r_idx;

    t_enc        enc;
    logic        out_fire, out_last, load, nonempty, fits;
    logic [32:0] end_pos;

    x86enc_encode u_enc (
        .i_item   (r_in),
        .i_offset (r_offset),
        .o_enc    (enc)
    );

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAP) ? r_cap : 32'd0;

    assign out_last = r_ovf || (r_idx == r_len - 7'd1);
    assign out_fire = r_busy && i_ready;
    // result register frees up on the last byte, so the next item loads then
    assign load     = r_in_vld && (!r_busy || (out_fire && out_last));
    assign o_ready  = !r_in_vld || load;

    assign end_pos  = {1'b0, r_offset} + {26'd0, enc.len};
    assign fits     = end_pos <= {1'b0, r_cap};
    assign nonempty = enc.bad || (enc.len != '0);

    assign o_valid         = r_busy;
    assign o_out.code_byte = r_ovf ? 8'd0
                           : (r_align ? OP_NOP : r_bytes[r_idx[IdxW-1:0]]);
    assign o_out.last_byte = out_last;
    assign o_out.overflow  = r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= 32'd4096;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAP) begin
            r_cap <= pwdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_offset <= '0;
            r_idx    <= '0;
            r_ovf    <= 1'b0;
        end else if (load) begin
            r_busy <= nonempty;
            r_idx  <= '0;
            r_ovf  <= enc.bad || !fits;
            if (!enc.bad && fits) begin
                r_offset <= end_pos[31:0];
            end
        end else if (out_fire) begin
            if (out_last) begin
                r_busy <= 1'b0;
            end
            r_idx <= r_idx + 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bytes <= enc.bytes;
            r_len   <= enc.len;
            r_align <= enc.is_align;
        end
    end

    // an overflow result is always a single, final word
    a_ovf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.overflow) |-> o_out.last_byte)
        else $error("overflow word not marked last");

    // byte index stays inside the instruction being sent
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_ovf) |-> (r_idx < r_len))
        else $error("byte index past instruction length");

    // offset never moves while bytes of an instruction are still going out
    a_off_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !load) |=> $stable(r_offset))
        else $error("offset changed mid-instruction");

endmodule
`default_nettype wire
